// File: src/fr_pkg.sv
package fr_pkg;

    localparam int SQA_STEPS  = 29;
    localparam int DIV_STEPS  = 16;
    localparam int SQB_STEPS  = 17;
    localparam int AMP_STEPS  = 31;
    localparam int AMP_LAT    = AMP_STEPS + 1;
    localparam int PIPE_DEPTH = 3 + SQA_STEPS + 1 + DIV_STEPS + 1 + SQB_STEPS + 2 + AMP_LAT + 1;

    localparam logic [15:0] KR_ONE  = 16'd32768;
    localparam logic [15:0] ETA_ONE = 16'd4096;

    typedef struct packed {
        logic        swapped;
        logic [15:0] ior;
        logic [16:0] ac16;
        logic        tir;
    } t_side;

endpackage

// File: src/fr_if.sv
interface fr_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] incident_x;
    logic signed [15:0] incident_y;
    logic signed [15:0] incident_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        [15:0] refractive_index;

    modport source (output valid, incident_x, incident_y, incident_z,
                    normal_x, normal_y, normal_z, refractive_index, input ready);
    modport sink   (input valid, incident_x, incident_y, incident_z,
                    normal_x, normal_y, normal_z, refractive_index, output ready);
endinterface

interface fr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] reflectance;
    logic        total_internal;

    modport source (output valid, reflectance, total_internal, input ready);
    modport sink   (input valid, reflectance, total_internal, output ready);
endinterface

// File: src/fresnel_reflectance_top.sv
// Channel | Dir | Payload                                              | Handshake
// i_in    | in  | incident_x/y/z, normal_x/y/z, refractive_index      | valid/ready
// o_out   | out | reflectance, total_internal                          | valid/ready
//
// One beat is accepted every cycle while the output is not stalled.
// The latency is set by the two bit-per-stage square roots, the quotient stages
// for Snell's law and the 31-stage amplitude dividers.
// Reset clears only the valid bits; the datapath needs none.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
module fresnel_reflectance_top import fr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    fr_in_if.sink    i_in,
    fr_out_if.source o_out
);

    logic w_en;
    logic r_vld [0:PIPE_DEPTH-1];

    assign w_en       = !r_vld[PIPE_DEPTH-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_DEPTH; k++) r_vld[k] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k < PIPE_DEPTH; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Products of the dot product.
    logic signed [31:0] r_p0, r_p1, r_p2;
    logic [15:0] r_ior1;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p0   <= i_in.incident_x * i_in.normal_x;
            r_p1   <= i_in.incident_y * i_in.normal_y;
            r_p2   <= i_in.incident_z * i_in.normal_z;
            r_ior1 <= (i_in.refractive_index == 16'd0) ? 16'd1 : i_in.refractive_index;
        end
    end

    // Sum, clamp and fold to a magnitude.
    logic signed [33:0] w_dot;
    logic [33:0] w_abs;
    logic [28:0] w_ac28;
    logic [28:0] r_ac28;
    logic        r_sw2;
    logic [15:0] r_ior2;
    assign w_dot  = $signed({{2{r_p0[31]}}, r_p0}) + $signed({{2{r_p1[31]}}, r_p1})
                  + $signed({{2{r_p2[31]}}, r_p2});
    assign w_abs  = w_dot[33] ? 34'(-w_dot) : 34'(w_dot);
    assign w_ac28 = (w_abs > 34'(1 << 28)) ? 29'(1 << 28) : w_abs[28:0];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ac28 <= w_ac28;
            r_sw2  <= !w_dot[33] && (w_dot != 34'sd0);
            r_ior2 <= r_ior1;
        end
    end

    // Radicand of sin_i, then a restoring square root, one result bit a stage.
    logic [57:0] w_sq1;
    logic [57:0] r_sa_v [0:SQA_STEPS];
    logic [57:0] r_sa_r [0:SQA_STEPS];
    t_side       r_sa_s [0:SQA_STEPS];
    assign w_sq1 = r_ac28 * r_ac28;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sa_v[0] <= 58'(58'd1 << 56) - w_sq1;
            r_sa_r[0] <= '0;
            r_sa_s[0] <= '{swapped: r_sw2, ior: r_ior2, ac16: r_ac28[28:12], tir: 1'b0};
        end
    end

    for (genvar k = 0; k < SQA_STEPS; k++) begin : g_sqa
        logic [57:0] w_bit, w_t;
        logic        w_ge;
        assign w_bit = 58'd1 << (2 * (SQA_STEPS - 1 - k));
        assign w_t   = r_sa_r[k] + w_bit;
        assign w_ge  = (r_sa_v[k] >= w_t);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sa_v[k+1] <= w_ge ? r_sa_v[k] - w_t : r_sa_v[k];
                r_sa_r[k+1] <= w_ge ? (r_sa_r[k] >> 1) + w_bit : r_sa_r[k] >> 1;
                r_sa_s[k+1] <= r_sa_s[k];
            end
        end
    end

    // Snell's law: the swapped case is a product; otherwise a quotient follows.
    logic [28:0] w_sini;
    logic [44:0] w_prod;
    logic        w_tir;
    t_side       w_side_t;
    logic [28:0] r_t_sini;
    logic [15:0] r_t_sts;
    t_side       r_t_s;
    assign w_sini = r_sa_r[SQA_STEPS][28:0];
    assign w_prod = w_sini * r_sa_s[SQA_STEPS].ior;
    assign w_tir  = r_sa_s[SQA_STEPS].swapped ? (w_prod[44:40] != 5'd0)
                  : ({3'b000, w_sini} >= {r_sa_s[SQA_STEPS].ior, 16'd0});
    always_comb begin
        w_side_t     = r_sa_s[SQA_STEPS];
        w_side_t.tir = w_tir;
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t_sini <= w_sini;
            r_t_sts  <= w_prod[39:24];
            r_t_s    <= w_side_t;
        end
    end

    logic [15:0] r_dv_rem [0:DIV_STEPS];
    logic [15:0] r_dv_q   [0:DIV_STEPS];
    logic [28:0] r_dv_n   [0:DIV_STEPS];
    logic [15:0] r_dv_sts [0:DIV_STEPS];
    t_side       r_dv_s   [0:DIV_STEPS];
    always_comb begin
        r_dv_rem[0] = {3'b000, r_t_sini[28:16]};
        r_dv_q[0]   = '0;
        r_dv_n[0]   = r_t_sini;
        r_dv_sts[0] = r_t_sts;
        r_dv_s[0]   = r_t_s;
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [16:0] w_rem2;
        logic        w_ge;
        assign w_rem2 = {r_dv_rem[k], r_dv_n[k][DIV_STEPS-1-k]};
        assign w_ge   = (w_rem2 >= {1'b0, r_dv_s[k].ior});
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_rem[k+1] <= w_ge ? 16'(w_rem2 - {1'b0, r_dv_s[k].ior}) : w_rem2[15:0];
                r_dv_q[k+1]   <= r_dv_q[k] | (16'(w_ge) << (DIV_STEPS - 1 - k));
                r_dv_n[k+1]   <= r_dv_n[k];
                r_dv_sts[k+1] <= r_dv_sts[k];
                r_dv_s[k+1]   <= r_dv_s[k];
            end
        end
    end

    // Radicand of cos_t and its square root.
    logic [15:0] w_st16;
    logic [31:0] w_sq2;
    logic [33:0] r_sb_v [0:SQB_STEPS];
    logic [33:0] r_sb_r [0:SQB_STEPS];
    t_side       r_sb_s [0:SQB_STEPS];
    assign w_st16 = r_dv_s[DIV_STEPS].swapped ? r_dv_sts[DIV_STEPS] : r_dv_q[DIV_STEPS];
    assign w_sq2  = w_st16 * w_st16;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb_v[0] <= 34'(34'd1 << 32) - {2'b00, w_sq2};
            r_sb_r[0] <= '0;
            r_sb_s[0] <= r_dv_s[DIV_STEPS];
        end
    end

    for (genvar k = 0; k < SQB_STEPS; k++) begin : g_sqb
        logic [33:0] w_bit, w_t;
        logic        w_ge;
        assign w_bit = 34'd1 << (2 * (SQB_STEPS - 1 - k));
        assign w_t   = r_sb_r[k] + w_bit;
        assign w_ge  = (r_sb_v[k] >= w_t);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sb_v[k+1] <= w_ge ? r_sb_v[k] - w_t : r_sb_v[k];
                r_sb_r[k+1] <= w_ge ? (r_sb_r[k] >> 1) + w_bit : r_sb_r[k] >> 1;
                r_sb_s[k+1] <= r_sb_s[k];
            end
        end
    end

    // Fresnel amplitude terms.
    t_side       w_sp;
    logic [16:0] w_ct16;
    logic [15:0] w_eta_i, w_eta_t;
    logic [32:0] r_a, r_b, r_c, r_d;
    t_side       r_p_s;
    assign w_sp    = r_sb_s[SQB_STEPS];
    assign w_ct16  = r_sb_r[SQB_STEPS][16:0];
    assign w_eta_i = w_sp.swapped ? w_sp.ior : ETA_ONE;
    assign w_eta_t = w_sp.swapped ? ETA_ONE : w_sp.ior;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a   <= w_eta_t * w_sp.ac16;
            r_b   <= w_eta_i * w_ct16;
            r_c   <= w_eta_i * w_sp.ac16;
            r_d   <= w_eta_t * w_ct16;
            r_p_s <= w_sp;
        end
    end

    logic [33:0] r_n1, r_d1, r_n2, r_d2;
    t_side       r_n_s;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n1  <= (r_a >= r_b) ? 34'(r_a - r_b) : 34'(r_b - r_a);
            r_d1  <= 34'(r_a) + 34'(r_b);
            r_n2  <= (r_c >= r_d) ? 34'(r_c - r_d) : 34'(r_d - r_c);
            r_d2  <= 34'(r_c) + 34'(r_d);
            r_n_s <= r_p_s;
        end
    end

    logic [61:0] w_rs, w_rp;
    t_side       r_am_s [0:AMP_LAT-1];

    fr_amp u_amp_s (.i_clk(i_clk), .i_en(w_en), .i_num(r_n1), .i_den(r_d1), .o_sq(w_rs));
    fr_amp u_amp_p (.i_clk(i_clk), .i_en(w_en), .i_num(r_n2), .i_den(r_d2), .o_sq(w_rp));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_am_s[0] <= r_n_s;
            for (int k = 1; k < AMP_LAT; k++) r_am_s[k] <= r_am_s[k-1];
        end
    end

    // Average, scale to Q1.15 and saturate.
    logic [62:0] w_sum;
    logic [16:0] w_kr;
    logic [15:0] r_refl;
    logic        r_tir;
    assign w_sum = {1'b0, w_rs} + {1'b0, w_rp};
    assign w_kr  = w_sum[62:46];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tir <= r_am_s[AMP_LAT-1].tir;
            if (r_am_s[AMP_LAT-1].tir || (w_kr > {1'b0, KR_ONE})) begin
                r_refl <= KR_ONE;
            end else begin
                r_refl <= w_kr[15:0];
            end
        end
    end

    assign o_out.valid          = r_vld[PIPE_DEPTH-1];
    assign o_out.reflectance    = r_refl;
    assign o_out.total_internal = r_tir;

endmodule

// File: src/fr_amp.sv
module fr_amp import fr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [33:0] i_num,
    input  logic [33:0] i_den,
    output logic [61:0] o_sq
);

    logic [34:0] r_rem [0:AMP_STEPS-1];
    logic [30:0] r_q   [0:AMP_STEPS-1];
    logic [33:0] r_den [0:AMP_STEPS-1];
    logic        r_dz  [0:AMP_STEPS-1];
    logic [61:0] r_sq;
    logic        w_ge0;

    // The numerator never exceeds the denominator, so the leading quotient bit
    // is a single compare and the remainder stays below the denominator.
    assign w_ge0 = (i_num >= i_den);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {1'b0, i_num - (w_ge0 ? i_den : 34'd0)};
            r_q[0]   <= {w_ge0, 30'd0};
            r_den[0] <= i_den;
            r_dz[0]  <= (i_den == 34'd0);
        end
    end

    for (genvar k = 1; k < AMP_STEPS; k++) begin : g_step
        logic [35:0] w_rem2;
        logic        w_ge;
        assign w_rem2 = {r_rem[k-1], 1'b0};
        assign w_ge   = (w_rem2 >= {2'b00, r_den[k-1]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? 35'(w_rem2 - {2'b00, r_den[k-1]}) : w_rem2[34:0];
                r_q[k]   <= r_q[k-1] | (31'(w_ge) << (AMP_STEPS - 1 - k));
                r_den[k] <= r_den[k-1];
                r_dz[k]  <= r_dz[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= r_dz[AMP_STEPS-1] ? 62'd0
                  : {31'd0, r_q[AMP_STEPS-1]} * {31'd0, r_q[AMP_STEPS-1]};
        end
    end

    assign o_sq = r_sq;

endmodule

// File: src/fr_chk.sv
module fr_chk import fr_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_reflectance,
    input logic        i_total_internal
);

    a_tir_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_total_internal |-> i_reflectance == KR_ONE)
        else $error("total internal reflection without full reflectance");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_reflectance <= KR_ONE)
        else $error("reflectance above one");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("input stalled while output can move");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_reflectance))
        else $error("stalled result beat changed");

endmodule

bind fresnel_reflectance_top fr_chk u_fr_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_reflectance   (o_out.reflectance),
    .i_total_internal(o_out.total_internal)
);
